>>> rtl/mp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the meshlet partitioner: word layouts of the
// request and response channels, result kinds and the control word of the cell row.
// No dependencies.
package mp_pkg;

   localparam int IDX_W   = 32;  // global vertex index
   localparam int LOCAL_W = 8;   // meshlet-local slot as seen on the port
   localparam int TOTAL_W = 7;   // descriptor counts as seen on the port

   typedef enum logic {
      MODE_TRIANGLE = 1'b0,
      MODE_FINISH   = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      KIND_VERTEX   = 2'd0,
      KIND_TRIANGLE = 2'd1,
      KIND_DESC     = 2'd2
   } kind_type;

   typedef struct packed {
      mode_type           mode;
      logic [IDX_W-1:0]   index_a;
      logic [IDX_W-1:0]   index_b;
      logic [IDX_W-1:0]   index_c;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic [IDX_W-1:0]   global_vertex;
      logic [LOCAL_W-1:0] local_first;
      logic [LOCAL_W-1:0] local_second;
      logic [LOCAL_W-1:0] local_third;
      logic [IDX_W-1:0]   desc_vertex_offset;
      logic [IDX_W-1:0]   desc_triangle_offset;
      logic [TOTAL_W-1:0] desc_vertex_total;
      logic [TOTAL_W-1:0] desc_triangle_total;
      logic               last;
   } rsp_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic               clear;   // drop all entries (new meshlet)
      logic               insert;  // append data at the first free cell
      logic [IDX_W-1:0]   data;
   } cell_ctl_type;

endpackage

>>> rtl/mp_req_if.sv
`timescale 1ns / 1ps
// Request channel of the meshlet partitioner: valid/ready plus one request word.
// Depends on mp_pkg.
interface mp_req_if;
   import mp_pkg::*;

   logic    valid;
   logic    ready;
   req_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);

endinterface

>>> rtl/mp_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the meshlet partitioner: valid/ready plus one result word.
// Depends on mp_pkg.
interface mp_rsp_if;
   import mp_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);

endinterface

>>> rtl/meshlet_partitioner_top.sv
`timescale 1ns / 1ps
// Top level of the greedy meshlet partitioner: vertex limit register, request
// holding register, cell row and sequencer.
// Depends on mp_pkg, mp_req_if, mp_rsp_if, mp_cell_row, mp_sequencer.
//
//   port       dir  handshake              word
//   req_chan   in   valid/ready            mode, index_a, index_b, index_c
//   rsp_chan   out  valid/ready            kind, vertex, slots, descriptor, last
//   csr_*      in   csr_write_en, no wait  vertex_limit
//
// A triangle yields one to five result words; its lookup in the cell row overlaps
// the previous triangle's last word, so words leave back to back while rsp_chan is
// ready. After an idle spell the first word passes the holding register, the plan
// registers and the output register. Skipped triangles leave the holding register
// unseen by the sequencer; a finish sends a descriptor only for a non-empty meshlet.
// Reset is synchronous and clears the row's valid flags at once, no sweep.
// req_chan.ready follows rsp_chan.ready combinationally while a word is pending.
module meshlet_partitioner_top #(
   parameter int MAX_VERTICES  = 64,
   parameter int MAX_TRIANGLES = 124
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic [mp_pkg::IDX_W-1:0] csr_write_data,
   mp_req_if.sink                   req_chan,
   mp_rsp_if.source                 rsp_chan
);
   import mp_pkg::*;

   localparam int SLOT_W = $clog2(MAX_VERTICES);

   logic [IDX_W-1:0]       vertex_limit_ff, vertex_limit_in;
   logic                   item_valid_ff, item_valid_in;
   req_type                item_ff, item_in;
   logic                   skip, take, item_take, req_fire;
   logic [2:0]             hit;
   logic [2:0][SLOT_W-1:0] slot;
   cell_ctl_type           ctl;

   // out-of-range triangles are dropped here without touching any state
   always_comb begin
      skip = (item_ff.mode == MODE_TRIANGLE)
          && ((item_ff.index_a >= vertex_limit_ff)
           || (item_ff.index_b >= vertex_limit_ff)
           || (item_ff.index_c >= vertex_limit_ff));
      item_take = item_valid_ff & (skip | take);
      req_chan.ready = ~item_valid_ff | item_take;
      req_fire = req_chan.valid & req_chan.ready;

      item_valid_in   = req_fire ? 1'b1 : (item_take ? 1'b0 : item_valid_ff);
      item_in         = req_fire ? req_chan.word : item_ff;
      vertex_limit_in = csr_write_en ? csr_write_data : vertex_limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         vertex_limit_ff <= '0;
      end else begin
         item_valid_ff   <= item_valid_in;
         vertex_limit_ff <= vertex_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   mp_cell_row #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_row (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .keys  ({item_ff.index_c, item_ff.index_b, item_ff.index_a}),
      .hit   (hit),
      .slot  (slot)
   );

   mp_sequencer #(
      .MAX_VERTICES  (MAX_VERTICES),
      .MAX_TRIANGLES (MAX_TRIANGLES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff & ~skip),
      .item       (item_ff),
      .hit        (hit),
      .slot       (slot),
      .take       (take),
      .ctl        (ctl),
      .rsp        (rsp_chan)
   );

endmodule

>>> rtl/mp_cell.sv
`timescale 1ns / 1ps
// One cell of the local vertex row: holds one global index of the open meshlet
// and compares it against the three corners of the triangle under lookup.
// Depends on mp_pkg.
module mp_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  mp_pkg::cell_ctl_type         ctl,
   input  logic                         prev_valid,
   input  logic [2:0][mp_pkg::IDX_W-1:0] keys,
   output logic                         valid,
   output logic [2:0]                   match
);
   import mp_pkg::*;

   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] entry_ff, entry_in;
   logic             write;

   // the first free cell is the empty one whose left neighbor is filled
   assign write = ctl.insert & prev_valid & ~valid_ff;

   always_comb begin
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (write) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff;
      end
      entry_in = write ? ctl.data : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // per-corner compare
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         match[k] = valid_ff & (entry_ff == keys[k]);
      end
   end

   assign valid = valid_ff;

endmodule

>>> rtl/mp_cell_row.sv
`timescale 1ns / 1ps
// Row of MAX_VERTICES vertex cells holding the open meshlet's vertex list, with
// the fill marker passed cell to cell and a per-corner slot encoder. Depends on mp_pkg, mp_cell.
module mp_cell_row #(
   parameter  int MAX_VERTICES = 64,
   localparam int SLOT_W       = $clog2(MAX_VERTICES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mp_pkg::cell_ctl_type          ctl,
   input  logic [2:0][mp_pkg::IDX_W-1:0] keys,
   output logic [2:0]                    hit,
   output logic [2:0][SLOT_W-1:0]        slot
);
   import mp_pkg::*;

   logic [MAX_VERTICES:0] chain;
   logic [2:0]            match [MAX_VERTICES];

   assign chain[0] = 1'b1;

   // cell i sees whether cell i-1 is filled
   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cells
      mp_cell u_vcell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_valid (chain[i]),
         .keys       (keys),
         .valid      (chain[i+1]),
         .match      (match[i])
      );
   end

   // entries of one meshlet are distinct, so at most one cell matches a corner
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hit[k]  = 1'b0;
         slot[k] = '0;
         for (int i = 0; i < MAX_VERTICES; i++) begin
            if (match[i][k]) begin
               hit[k]  = 1'b1;
               slot[k] = slot[k] | SLOT_W'(i);
            end
         end
      end
   end

endmodule

>>> rtl/mp_sequencer.sv
`timescale 1ns / 1ps
// Meshlet bookkeeping and result sequencer: latches one looked-up triangle, decides on a
// meshlet split, drives the cell row and emits descriptor, new vertices and triangle one
// word a cycle, while rsp is ready, via an output register. Depends on mp_pkg, mp_rsp_if.
module mp_sequencer #(
   parameter  int MAX_VERTICES  = 64,
   parameter  int MAX_TRIANGLES = 124,
   localparam int SLOT_W        = $clog2(MAX_VERTICES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  mp_pkg::req_type        item,
   input  logic [2:0]             hit,
   input  logic [2:0][SLOT_W-1:0] slot,
   output logic                   take,
   output mp_pkg::cell_ctl_type   ctl,
   mp_rsp_if.source               rsp
);
   import mp_pkg::*;

   localparam int VF_W = $clog2(MAX_VERTICES + 1);
   localparam int TF_W = $clog2(MAX_TRIANGLES + 1);

   typedef enum logic [2:0] {
      STEP_DESC,
      STEP_V0,
      STEP_V1,
      STEP_V2,
      STEP_TRI,
      STEP_END
   } step_type;

   typedef struct packed {
      logic                   desc;
      logic [2:0]             fresh;
      logic [2:0][SLOT_W-1:0] slot;
   } dec_type;

   // plan: the triangle under work
   logic                          plan_valid_ff, plan_valid_in;
   mode_type                      plan_mode_ff, plan_mode_in;
   logic [2:0][IDX_W-1:0]         plan_idx_ff, plan_idx_in;
   logic [2:0]                    plan_hit_ff, plan_hit_in;
   logic [2:0][SLOT_W-1:0]        plan_hslot_ff, plan_hslot_in;
   logic [2:0]                    plan_eq_ff, plan_eq_in;  // ab, ac, bc
   logic                          dec_valid_ff, dec_valid_in;
   dec_type                       dec_ff, dec_in;
   logic [4:0]                    done_ff, done_in;
   // meshlet state
   logic [VF_W-1:0]               vfill_ff, vfill_in;
   logic [TF_W-1:0]               tfill_ff, tfill_in;
   logic [IDX_W-1:0]              vbase_ff, vbase_in;
   logic [IDX_W-1:0]              tbase_ff, tbase_in;
   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_word_ff, rsp_word_in;

   dec_type                       dec_comb, dec;
   logic [1:0]                    added;
   logic [VF_W:0]                 vsum;
   logic                          split;
   logic [SLOT_W-1:0]             f0;
   logic [4:0]                    need, pend, step_bit;
   step_type                      step;
   logic                          out_free, fire, out_fire, load, retire, split_fire;
   rsp_type                       word;

   // split decision and slot assignment from the latched lookup
   always_comb begin
      added = {1'b0, ~plan_hit_ff[0]}
            + {1'b0, ~plan_hit_ff[1] & ~plan_eq_ff[0]}
            + {1'b0, ~plan_hit_ff[2] & ~plan_eq_ff[1] & ~plan_eq_ff[2]};
      vsum  = (VF_W+1)'(vfill_ff) + (VF_W+1)'(added);
      split = (tfill_ff >= TF_W'(MAX_TRIANGLES)) || (vsum > (VF_W+1)'(MAX_VERTICES));
      f0    = split ? '0 : vfill_ff[SLOT_W-1:0];

      dec_comb          = '0;
      dec_comb.fresh[0] = split | ~plan_hit_ff[0];
      dec_comb.fresh[1] = ~plan_eq_ff[0] & (split | ~plan_hit_ff[1]);
      dec_comb.fresh[2] = ~plan_eq_ff[1] & ~plan_eq_ff[2] & (split | ~plan_hit_ff[2]);

      dec_comb.slot[0] = dec_comb.fresh[0] ? f0 : plan_hslot_ff[0];
      if (dec_comb.fresh[1]) begin
         dec_comb.slot[1] = f0 + SLOT_W'(dec_comb.fresh[0]);
      end else if (plan_eq_ff[0]) begin
         dec_comb.slot[1] = dec_comb.slot[0];
      end else begin
         dec_comb.slot[1] = plan_hslot_ff[1];
      end
      if (dec_comb.fresh[2]) begin
         dec_comb.slot[2] = f0 + SLOT_W'(dec_comb.fresh[0]) + SLOT_W'(dec_comb.fresh[1]);
      end else if (plan_eq_ff[1]) begin
         dec_comb.slot[2] = dec_comb.slot[0];
      end else if (plan_eq_ff[2]) begin
         dec_comb.slot[2] = dec_comb.slot[1];
      end else begin
         dec_comb.slot[2] = plan_hslot_ff[2];
      end

      if (plan_mode_ff == MODE_FINISH) begin
         dec_comb.desc  = (tfill_ff != '0);
         dec_comb.fresh = '0;
      end else begin
         dec_comb.desc  = split && (tfill_ff != '0);
      end

      // decision is taken once, against the state seen when the plan is first valid, then held
      dec = dec_valid_ff ? dec_ff : dec_comb;
   end

   // next step: descriptor, new vertices, triangle, or a silent end for finish
   always_comb begin
      need = {plan_mode_ff == MODE_TRIANGLE, dec.fresh, dec.desc};
      pend = need & ~done_ff;
      if (pend[0]) begin
         step = STEP_DESC;
      end else if (pend[1]) begin
         step = STEP_V0;
      end else if (pend[2]) begin
         step = STEP_V1;
      end else if (pend[3]) begin
         step = STEP_V2;
      end else if (pend[4]) begin
         step = STEP_TRI;
      end else begin
         step = STEP_END;
      end

      case (step)
         STEP_DESC: step_bit = 5'b00001;
         STEP_V0:   step_bit = 5'b00010;
         STEP_V1:   step_bit = 5'b00100;
         STEP_V2:   step_bit = 5'b01000;
         STEP_TRI:  step_bit = 5'b10000;
         default:   step_bit = 5'b00000;
      endcase

      out_free   = ~rsp_valid_ff | rsp.ready;
      fire       = plan_valid_ff & ((step == STEP_END) | out_free);
      out_fire   = fire & (step != STEP_END);
      retire     = fire & ((step == STEP_TRI) | (step == STEP_END));
      // next lookup may overlap the triangle word: the row does not change then
      take       = ~plan_valid_ff | (fire & (step == STEP_TRI));
      load       = item_valid & take;
      split_fire = fire & (step == STEP_DESC) & (plan_mode_ff == MODE_TRIANGLE);
   end

   // result word
   always_comb begin
      word = '0;
      case (step)
         STEP_DESC: begin
            word.kind                 = KIND_DESC;
            word.desc_vertex_offset   = vbase_ff;
            word.desc_triangle_offset = tbase_ff;
            word.desc_vertex_total    = TOTAL_W'(vfill_ff);
            word.desc_triangle_total  = TOTAL_W'(tfill_ff);
            word.last                 = (plan_mode_ff == MODE_FINISH);
         end
         STEP_V0: begin
            word.kind          = KIND_VERTEX;
            word.global_vertex = plan_idx_ff[0];
         end
         STEP_V1: begin
            word.kind          = KIND_VERTEX;
            word.global_vertex = plan_idx_ff[1];
         end
         STEP_V2: begin
            word.kind          = KIND_VERTEX;
            word.global_vertex = plan_idx_ff[2];
         end
         STEP_TRI: begin
            word.kind         = KIND_TRIANGLE;
            word.local_first  = LOCAL_W'(dec.slot[0]);
            word.local_second = LOCAL_W'(dec.slot[1]);
            word.local_third  = LOCAL_W'(dec.slot[2]);
            word.last         = 1'b1;
         end
         default: begin
            word = '0;
         end
      endcase
   end

   // cell row control
   always_comb begin
      ctl.clear  = split_fire | (fire & (step == STEP_END));
      ctl.insert = fire & ((step == STEP_V0) | (step == STEP_V1) | (step == STEP_V2));
      case (step)
         STEP_V1: ctl.data = plan_idx_ff[1];
         STEP_V2: ctl.data = plan_idx_ff[2];
         default: ctl.data = plan_idx_ff[0];
      endcase
   end

   // next state
   always_comb begin
      plan_valid_in = load ? 1'b1 : (retire ? 1'b0 : plan_valid_ff);
      dec_valid_in  = load ? 1'b0 : (plan_valid_ff | dec_valid_ff);
      dec_in        = plan_valid_ff ? dec : dec_ff;
      done_in       = load ? '0 : (fire ? (done_ff | step_bit) : done_ff);

      plan_mode_in  = load ? item.mode : plan_mode_ff;
      plan_idx_in   = load ? {item.index_c, item.index_b, item.index_a} : plan_idx_ff;
      plan_hit_in   = load ? hit : plan_hit_ff;
      plan_hslot_in = load ? slot : plan_hslot_ff;
      plan_eq_in    = load ? {item.index_b == item.index_c,
                              item.index_a == item.index_c,
                              item.index_a == item.index_b} : plan_eq_ff;

      vfill_in = vfill_ff;
      tfill_in = tfill_ff;
      vbase_in = vbase_ff;
      tbase_in = tbase_ff;
      if (fire && step == STEP_END) begin
         vfill_in = '0;
         tfill_in = '0;
         vbase_in = '0;
         tbase_in = '0;
      end else if (split_fire) begin
         vfill_in = '0;
         tfill_in = '0;
         vbase_in = vbase_ff + IDX_W'(vfill_ff);
         tbase_in = tbase_ff + IDX_W'(tfill_ff);
      end else if (ctl.insert) begin
         vfill_in = vfill_ff + 1'b1;
      end else if (fire && step == STEP_TRI) begin
         tfill_in = tfill_ff + 1'b1;
      end

      rsp_valid_in = out_fire ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
      rsp_word_in  = out_fire ? word : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_valid_ff <= 1'b0;
         dec_valid_ff  <= 1'b0;
         done_ff       <= '0;
         vfill_ff      <= '0;
         tfill_ff      <= '0;
         vbase_ff      <= '0;
         tbase_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         plan_valid_ff <= plan_valid_in;
         dec_valid_ff  <= dec_valid_in;
         done_ff       <= done_in;
         vfill_ff      <= vfill_in;
         tfill_ff      <= tfill_in;
         vbase_ff      <= vbase_in;
         tbase_ff      <= tbase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_mode_ff  <= plan_mode_in;
      plan_idx_ff   <= plan_idx_in;
      plan_hit_ff   <= plan_hit_in;
      plan_hslot_ff <= plan_hslot_in;
      plan_eq_ff    <= plan_eq_in;
      dec_ff        <= dec_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.word  = rsp_word_ff;

endmodule
